### rtl/png_pkg.sv
// Shared types, constants and coefficient table of the pink noise generator.
package png_pkg;

    localparam int TAP_W   = 40;   // filter state, 30 fraction bits
    localparam int SUM_W   = 44;   // weighted sum before clamping
    localparam int OPA_W   = 33;   // multiplier operand A
    localparam int K_W     = 25;   // coefficient, 24 fraction bits
    localparam int PROD_W  = OPA_W + K_W;
    localparam int ACC_W   = 66;   // holds a full tap times coefficient product
    localparam int SPLIT   = 20;   // wide operands are split at this bit
    localparam int FB_W    = ACC_W - 24;
    localparam int WT_W    = PROD_W - 25;
    localparam int OUT_W   = 24;
    localparam int N_TAPS  = 7;

    localparam logic [2:0]  TAP_SUB  = 3'd5;   // filter whose input term is subtracted
    localparam logic [2:0]  TAP_DLY  = 3'd6;   // delayed tap
    localparam logic [2:0]  TAP_LAST = 3'd5;   // last one-pole filter
    localparam logic [31:0] SEED_RST = 32'd12648430;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAP,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        MS_TAP_LO,
        MS_TAP_HI,
        MS_W,
        MS_SUM_LO,
        MS_SUM_HI
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_HI
    } t_acc_op;

    typedef enum logic [2:0] {
        SUM_HOLD,
        SUM_NEW,
        SUM_DELAY,
        SUM_WT,
        SUM_CLAMP
    } t_sum_op;

    typedef enum logic [3:0] {
        C_POLE0, C_POLE1, C_POLE2, C_POLE3, C_POLE4, C_POLE5,
        C_GAIN0, C_GAIN1, C_GAIN2, C_GAIN3, C_GAIN4, C_GAIN5,
        C_DIRECT,
        C_DELAY,
        C_OUT
    } t_coef;

    typedef struct packed {
        logic     load;
        t_mul_sel mul_sel;
        t_coef    coef;
        logic [2:0] idx;
        t_acc_op  acc_op;
        logic     rnd;
        logic     tap_wr;
        logic     dly_wr;
        t_sum_op  sum_op;
        logic     out_ld;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic logic signed [K_W-1:0] coef_value(input t_coef c);
        logic signed [K_W-1:0] v;
        case (c)
            C_POLE0:  v = 25'sd16758090;
            C_POLE1:  v = 25'sd16665144;
            C_POLE2:  v = 25'sd16257122;
            C_POLE3:  v = 25'sd14537458;
            C_POLE4:  v = 25'sd9227469;
            C_POLE5:  v = -25'sd12777528;
            C_GAIN0:  v = 25'sd931436;
            C_GAIN1:  v = 25'sd1259565;
            C_GAIN2:  v = 25'sd2581208;
            C_GAIN3:  v = 25'sd5209084;
            C_GAIN4:  v = 25'sd8941454;
            C_GAIN5:  v = 25'sd283501;
            C_DIRECT: v = 25'sd8995943;
            C_DELAY:  v = 25'sd1944916;
            C_OUT:    v = 25'sd1845494;
            default:  v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/png_ctrl.sv
// Sequencer that steps the shared multiplier datapath through one sample.
module png_ctrl
    import png_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_tap, n_tap;
    logic [2:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tap   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_tap      = r_tap;
        n_step     = r_step;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        o_cmd.idx  = r_tap;

        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_TAP;
                    n_tap      = '0;
                    n_step     = '0;
                end
            end

            ST_TAP: begin
                // Five steps per filter: two half products of the pole term,
                // the input term, rounding, then the saturated write back.
                case (r_step)
                    3'd0: begin
                        o_cmd.mul_sel = MS_TAP_LO;
                        o_cmd.coef    = t_coef'({1'b0, r_tap});
                        o_cmd.sum_op  = SUM_NEW;
                    end
                    3'd1: begin
                        o_cmd.mul_sel = MS_TAP_HI;
                        o_cmd.coef    = t_coef'({1'b0, r_tap});
                        o_cmd.acc_op  = ACC_LOAD;
                    end
                    3'd2: begin
                        o_cmd.mul_sel = MS_W;
                        o_cmd.coef    = t_coef'({1'b0, r_tap} + C_GAIN0);
                        o_cmd.acc_op  = ACC_ADD_HI;
                    end
                    3'd3: begin
                        o_cmd.rnd = 1'b1;
                    end
                    3'd4: begin
                        o_cmd.tap_wr = 1'b1;
                    end
                    default: begin
                        o_cmd.rnd = 1'b0;
                    end
                endcase
                if (r_step == 3'd4) begin
                    n_step = '0;
                    if (r_tap == TAP_LAST) begin
                        n_state = ST_FIN;
                    end else begin
                        n_tap = r_tap + 3'd1;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end

            ST_FIN: begin
                n_step = r_step + 3'd1;
                case (r_step)
                    3'd0: begin
                        o_cmd.mul_sel = MS_W;
                        o_cmd.coef    = C_DIRECT;
                        o_cmd.sum_op  = SUM_NEW;
                    end
                    3'd1: begin
                        o_cmd.mul_sel = MS_W;
                        o_cmd.coef    = C_DELAY;
                        o_cmd.rnd     = 1'b1;
                        o_cmd.sum_op  = SUM_DELAY;
                    end
                    3'd2: begin
                        o_cmd.rnd    = 1'b1;
                        o_cmd.sum_op = SUM_WT;
                    end
                    3'd3: begin
                        o_cmd.dly_wr = 1'b1;
                        o_cmd.sum_op = SUM_CLAMP;
                    end
                    3'd4: begin
                        o_cmd.mul_sel = MS_SUM_LO;
                        o_cmd.coef    = C_OUT;
                    end
                    3'd5: begin
                        o_cmd.mul_sel = MS_SUM_HI;
                        o_cmd.coef    = C_OUT;
                        o_cmd.acc_op  = ACC_LOAD;
                    end
                    3'd6: begin
                        o_cmd.acc_op = ACC_ADD_HI;
                    end
                    3'd7: begin
                        // Wait here until the output register can take the sample.
                        n_step = r_step;
                        if (i_sts.out_free) begin
                            o_cmd.out_ld = 1'b1;
                            n_state      = ST_IDLE;
                            n_step       = '0;
                        end
                    end
                    default: begin
                        n_step = '0;
                    end
                endcase
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/png_dp.sv
// Datapath: generator, filter taps, shared multiplier, accumulator and output register.
module png_dp
    import png_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [31:0]             i_cfg_seed,
    input  logic                    i_start_new,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output logic signed [OUT_W-1:0] o_sample,
    output logic                    o_clipped
);

    logic [31:0]               r_seed;
    logic [31:0]               r_rng;
    logic signed [31:0]        r_w;
    logic signed [TAP_W-1:0]   r_taps [N_TAPS];
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [FB_W-1:0]    r_fb;
    logic signed [WT_W-1:0]    r_wt;
    logic signed [TAP_W-1:0]   r_new;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic                      r_out_valid;
    logic signed [OUT_W-1:0]   r_sample;
    logic                      r_clipped;

    logic [31:0]               s0, x1, x2, x3;
    logic signed [TAP_W-1:0]   tap_sel;
    logic signed [OPA_W-1:0]   op_a;
    logic signed [K_W-1:0]     op_k;
    logic signed [PROD_W-1:0]  mul;
    logic signed [ACC_W-1:0]   fb_full, y_full;
    logic signed [PROD_W-1:0]  wt_full;
    logic signed [TAP_W+2:0]   tap_sum;
    logic signed [TAP_W-1:0]   tap_sat;
    logic signed [34:0]        y;
    logic                      y_fits;

    // Generator: a start reloads from the seed, with zero replaced by one.
    always_comb begin
        if (i_start_new) begin
            s0 = (r_seed == 32'd0) ? 32'd1 : r_seed;
        end else begin
            s0 = r_rng;
        end
        x1 = s0 ^ (s0 << 13);
        x2 = x1 ^ (x1 >> 17);
        x3 = x2 ^ (x2 << 5);
    end

    assign tap_sel = r_taps[i_cmd.idx];
    assign op_k    = coef_value(i_cmd.coef);

    always_comb begin
        case (i_cmd.mul_sel)
            MS_TAP_LO: op_a = {{(OPA_W-SPLIT){1'b0}}, tap_sel[SPLIT-1:0]};
            MS_TAP_HI: op_a = {{(OPA_W-SPLIT){tap_sel[TAP_W-1]}}, tap_sel[TAP_W-1:SPLIT]};
            MS_W:      op_a = {r_w[31], r_w};
            MS_SUM_LO: op_a = {{(OPA_W-SPLIT){1'b0}}, r_sum[SPLIT-1:0]};
            MS_SUM_HI: op_a = {{(OPA_W-SPLIT){r_sum[TAP_W-1]}}, r_sum[TAP_W-1:SPLIT]};
            default:   op_a = '0;
        endcase
    end

    assign mul = op_a * op_k;

    always_comb begin
        case (i_cmd.acc_op)
            ACC_LOAD:   n_acc = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            ACC_ADD_HI: n_acc = r_acc + {r_prod[ACC_W-SPLIT-1:0], {SPLIT{1'b0}}};
            default:    n_acc = r_acc;
        endcase
    end

    // Round half up by adding half an output step before the floor shift.
    assign fb_full = r_acc + (ACC_W'(1) << 23);
    assign wt_full = r_prod + (PROD_W'(1) << 24);

    always_comb begin
        if (i_cmd.idx == TAP_SUB) begin
            tap_sum = {r_fb[FB_W-1], r_fb} - {{(TAP_W+3-WT_W){r_wt[WT_W-1]}}, r_wt};
        end else begin
            tap_sum = {r_fb[FB_W-1], r_fb} + {{(TAP_W+3-WT_W){r_wt[WT_W-1]}}, r_wt};
        end
        if (tap_sum[TAP_W+2:TAP_W-1] == '0 || tap_sum[TAP_W+2:TAP_W-1] == '1) begin
            tap_sat = tap_sum[TAP_W-1:0];
        end else if (tap_sum[TAP_W+2]) begin
            tap_sat = {1'b1, {(TAP_W-1){1'b0}}};
        end else begin
            tap_sat = {1'b0, {(TAP_W-1){1'b1}}};
        end
    end

    always_comb begin
        case (i_cmd.sum_op)
            SUM_NEW:   n_sum = r_sum + {{(SUM_W-TAP_W){r_new[TAP_W-1]}}, r_new};
            SUM_DELAY: n_sum = r_sum + {{(SUM_W-TAP_W){r_taps[TAP_DLY][TAP_W-1]}},
                                        r_taps[TAP_DLY]};
            SUM_WT:    n_sum = r_sum + {{(SUM_W-WT_W){r_wt[WT_W-1]}}, r_wt};
            SUM_CLAMP: begin
                if (r_sum[SUM_W-1:35] == '0 || r_sum[SUM_W-1:35] == '1) begin
                    n_sum = r_sum;
                end else if (r_sum[SUM_W-1]) begin
                    n_sum = {{(SUM_W-35){1'b1}}, 35'd0};
                end else begin
                    n_sum = {{(SUM_W-35){1'b0}}, {35{1'b1}}};
                end
            end
            default:   n_sum = r_sum;
        endcase
    end

    assign y_full = r_acc + (ACC_W'(1) << 30);
    assign y      = y_full[65:31];
    assign y_fits = (y[34:OUT_W-1] == '0) || (y[34:OUT_W-1] == '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RST;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng <= SEED_RST;
        end else if (i_cmd.load) begin
            r_rng <= x3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_TAPS; i++) begin
                r_taps[i] <= '0;
            end
        end else if (i_cmd.load && i_start_new) begin
            for (int i = 0; i < N_TAPS; i++) begin
                r_taps[i] <= '0;
            end
        end else begin
            if (i_cmd.tap_wr) begin
                r_taps[i_cmd.idx] <= tap_sat;
            end
            if (i_cmd.dly_wr) begin
                r_taps[TAP_DLY] <= {{(TAP_W-WT_W){r_wt[WT_W-1]}}, r_wt};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul;
        r_acc  <= n_acc;
        if (i_cmd.load) begin
            r_w   <= {~x3[31], x3[30:0]};
            r_sum <= '0;
            r_new <= '0;
        end else begin
            r_sum <= n_sum;
            if (i_cmd.tap_wr) begin
                r_new <= tap_sat;
            end
        end
        if (i_cmd.rnd) begin
            r_fb <= fb_full[ACC_W-1:24];
            r_wt <= wt_full[PROD_W-1:25];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_clipped <= !y_fits;
            if (y_fits) begin
                r_sample <= y[OUT_W-1:0];
            end else if (y[34]) begin
                r_sample <= {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
                r_sample <= {1'b0, {(OUT_W-1){1'b1}}};
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_sample       = r_sample;
    assign o_clipped      = r_clipped;

endmodule

### rtl/pink_noise_generator_unit.sv
// Top level of the pink noise generator: sequencer plus shared-multiplier datapath.
//
//   Channel   Direction  Handshake                     Payload
//   -------   ---------  ----------------------------  --------------------------
//   in        input      i_in_valid / o_in_stall       i_start_new
//   out       output     o_out_valid / i_out_stall     o_sample, o_clipped
//   cfg       input      i_cfg_valid / o_cfg_ready     i_cfg_seed
//
// An item is taken in the idle state; the sequencer then runs the six filters and forms
// the direct, delayed and output terms, and only after the result is loaded into the
// output register does it return to idle and take the next item. The single 33 x 25 bit
// multiplier is shared by all terms; it makes 22 passes for the 15 coefficient products,
// since each 40-bit filter tap and the clamped sum go through it as two 20-bit halves.
// Reset is synchronous and active low; it loads the reset seed into the
// generator, clears all filter taps and empties the output register.
// A stalled output holds only the final write of the next result; a new item
// is taken while an earlier result still waits in the output register.
module pink_noise_generator_unit
    import png_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_start_new,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [OUT_W-1:0] o_sample,
    output logic                    o_clipped,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [31:0]             i_cfg_seed
);

    t_cmd w_cmd;
    t_sts w_sts;

    // The seed register is always free to be written; it only takes effect
    // when an item with the start flag reloads the generator.
    assign o_cfg_ready = 1'b1;

    // The sequencer walks each filter through five steps (two half products
    // of the pole term, the input term, rounding, saturated write back) and
    // then forms the direct and delayed terms and the scaled output.
    png_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    png_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_seed  (i_cfg_seed),
        .i_start_new (i_start_new),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_sample    (o_sample),
        .o_clipped   (o_clipped)
    );

    // Once an item is taken the block is busy on the following cycle.
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall
    ) else $error("input not stalled after an item was accepted");

    // A result is never written over one that is still waiting.
    a_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_ld |-> !(o_out_valid && i_out_stall)
    ) else $error("output register loaded while holding a stalled result");

    // The output only turns valid as a result of a load from the sequencer.
    a_valid_from_load: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.out_ld)
    ) else $error("output valid rose without a load command");

endmodule

### verif/pink_noise_checker.sv
// Checker for the pink noise generator: predicts every sample and compares it with the block.
`timescale 1ns / 100ps

module pink_noise_checker
    import png_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic                    i_start_new,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [OUT_W-1:0] i_sample,
    input  logic                    i_clipped,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [31:0]             i_cfg_seed,
    output int                      o_pending,
    output int                      o_errors,
    output int                      o_results,
    output int                      o_clips
);

    typedef logic signed [79:0] t_wide;

    typedef struct packed {
        logic signed [OUT_W-1:0] sample;
        logic                    clipped;
    } t_pink_result;

    localparam t_wide TAP_HI = 80'sd549755813887;
    localparam t_wide TAP_LO = -80'sd549755813888;
    localparam t_wide SUM_HI = 80'sd34359738367;
    localparam t_wide SUM_LO = -80'sd34359738368;
    localparam t_wide OUT_HI = 80'sd8388607;
    localparam t_wide OUT_LO = -80'sd8388608;
    localparam t_wide K_DIRECT = 80'sd8995943;
    localparam t_wide K_DELAY  = 80'sd1944916;
    localparam t_wide K_SCALE  = 80'sd1845494;

    logic [31:0]  seed_copy;
    logic [31:0]  rng_state;
    t_wide        tap_state [0:N_TAPS-1];
    t_pink_result expected_samples [$];
    t_pink_result want;
    int           errors;
    int           results;
    int           clips;

    function automatic t_wide pole_coef(input int i);
        t_wide c;
        case (i)
            0:       c = 80'sd16758090;
            1:       c = 80'sd16665144;
            2:       c = 80'sd16257122;
            3:       c = 80'sd14537458;
            4:       c = 80'sd9227469;
            default: c = -80'sd12777528;
        endcase
        return c;
    endfunction

    function automatic t_wide gain_coef(input int i);
        t_wide c;
        case (i)
            0:       c = 80'sd931436;
            1:       c = 80'sd1259565;
            2:       c = 80'sd2581208;
            3:       c = 80'sd5209084;
            4:       c = 80'sd8941454;
            default: c = 80'sd283501;
        endcase
        return c;
    endfunction

    // Round half up, then drop n fraction bits (arithmetic shift floors).
    function automatic t_wide round_shift(input t_wide x, input int n);
        return (x + (t_wide'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic t_wide clamp_wide(input t_wide x, input t_wide lo, input t_wide hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    // Advances the generator and filters by one sample and returns what the block must emit.
    function automatic t_pink_result next_pink_sample(input logic start);
        logic [31:0]  s;
        t_wide        w;
        t_wide        prod;
        t_wide        fb;
        t_wide        wt;
        t_wide        p;
        t_wide        y;
        t_pink_result r;
        if (start) begin
            rng_state = (seed_copy == 32'd0) ? 32'd1 : seed_copy;
            for (int i = 0; i < N_TAPS; i++) tap_state[i] = '0;
        end
        s = rng_state;
        s ^= s << 13;
        s ^= s >> 17;
        s ^= s << 5;
        rng_state = s;
        w = t_wide'(s) - 80'sd2147483648;
        for (int i = 0; i < 6; i++) begin
            prod = tap_state[i] * pole_coef(i);
            fb = round_shift(prod, 24);
            prod = w * gain_coef(i);
            wt = round_shift(prod, 25);
            tap_state[i] = clamp_wide((i == 5) ? fb - wt : fb + wt, TAP_LO, TAP_HI);
        end
        prod = w * K_DIRECT;
        p = round_shift(prod, 25);
        // The delayed tap enters the sum with its old value.
        for (int i = 0; i < N_TAPS; i++) p = p + tap_state[i];
        prod = w * K_DELAY;
        tap_state[N_TAPS-1] = round_shift(prod, 25);
        p = clamp_wide(p, SUM_LO, SUM_HI);
        prod = p * K_SCALE;
        y = round_shift(prod, 31);
        r.clipped = (y > OUT_HI) || (y < OUT_LO);
        y = clamp_wide(y, OUT_LO, OUT_HI);
        r.sample = y[OUT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seed_copy = SEED_RST;
            rng_state = SEED_RST;
            for (int i = 0; i < N_TAPS; i++) tap_state[i] = '0;
            expected_samples.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) seed_copy = i_cfg_seed;
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (expected_samples.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected item: sample %0d clipped %0b",
                                 i_sample, i_clipped);
                end else begin
                    want = expected_samples.pop_front();
                    if (want.clipped) clips++;
                    if (i_sample !== want.sample || i_clipped !== want.clipped) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch on result %0d: expected sample %0d ",
                                      "clipped %0b, got sample %0d clipped %0b"},
                                     results, want.sample, want.clipped,
                                     i_sample, i_clipped);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_samples.push_back(next_pink_sample(i_start_new));
        end
        o_pending <= expected_samples.size();
        o_errors  <= errors;
        o_results <= results;
        o_clips   <= clips;
    end

endmodule

### verif/tb.sv
// Testbench top for the pink noise generator: reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb
    import png_pkg::*;
();

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_start_new;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [OUT_W-1:0] o_sample;
    logic                    o_clipped;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [31:0]             i_cfg_seed;

    int pending;
    int errors;
    int results;
    int clips;

    // When set, both sides run without any idle or stall cycles.
    bit quiet;
    int items_sent;
    int starts_sent;
    int seeds_written;

    pink_noise_generator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_start_new (i_start_new),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample),
        .o_clipped   (o_clipped),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_seed  (i_cfg_seed)
    );

    // The checker watches all three channels beside the block and keeps the expected samples.
    pink_noise_checker sample_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_start_new (i_start_new),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sample    (o_sample),
        .i_clipped   (o_clipped),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_seed  (i_cfg_seed),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_results   (results),
        .o_clips     (clips)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // A generous fixed limit; a correct run needs well under a millisecond.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Each side draws its own wait for every item.
    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 13);
    endfunction

    // Sends one item. It is entered and left at a falling edge. The valid line is only
    // lowered when a gap follows, so back-to-back items keep it high without a glitch.
    task automatic send_item(input logic start);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_start_new <= start;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (start) starts_sent++;
        @(negedge i_clk);
    endtask

    // Writes the seed register. The seed is only changed while the block is idle, so the
    // task first waits until every expected sample has come out.
    task automatic load_seed(input logic [31:0] value);
        i_in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_seed  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        seeds_written++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver. For each result it either stalls a drawn number of cycles right after the
    // previous item, or holds stall until a result shows up and then keeps it a while longer,
    // so that stalls land both on waiting results and on the block's compute phase.
    initial begin
        int  hold;
        bit  on_valid;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            hold = draw_wait();
            on_valid = !quiet && ($urandom_range(0, 1) == 1);
            if (on_valid) begin
                i_out_stall <= 1'b1;
                do @(posedge i_clk); while (!o_out_valid);
                @(negedge i_clk);
                repeat (hold) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    initial begin
        int          phase_len;
        logic [31:0] seed_value;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_start_new = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_seed  = '0;
        quiet       = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. First the generator runs from its reset state without any start.
        repeat (3) send_item(1'b0);
        // A zero seed must be replaced by one.
        load_seed(32'd0);
        send_item(1'b1);
        repeat (2) send_item(1'b0);
        // All-ones seed, then two starts in a row to see the sequence restart identically.
        load_seed(32'hFFFF_FFFF);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b1);
        // Top bit only, and the smallest nonzero seed.
        load_seed(32'h8000_0000);
        send_item(1'b1);
        send_item(1'b0);
        load_seed(32'd1);
        send_item(1'b1);
        repeat (3) send_item(1'b0);
        // Back-to-back items with no idling at all.
        quiet = 1'b1;
        load_seed(SEED_RST);
        send_item(1'b1);
        repeat (3) send_item(1'b0);

        // Random part: phases with a fresh seed, mostly started, with rare restarts inside.
        while (items_sent < 520) begin
            case ($urandom_range(0, 7))
                0:       seed_value = 32'd0;
                1:       seed_value = 32'hFFFF_FFFF;
                default: seed_value = $urandom();
            endcase
            load_seed(seed_value);
            quiet = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(10, 60);
            send_item($urandom_range(0, 3) != 0);
            repeat (phase_len - 1) send_item($urandom_range(0, 19) == 0);
        end

        i_in_valid <= 1'b0;
        wait (pending == 0);
        // Let any stray result surface before the verdict.
        repeat (60) @(posedge i_clk);

        $display("covered %0d items (%0d with a restart) over %0d seed settings,",
                 items_sent, starts_sent, seeds_written);
        $display("checked %0d samples, %0d of them saturated", results, clips);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
